// ===== sv/gcmp_pkg.sv =====
// shared types and constants for the gated cube to matrix projection block
`timescale 1ns / 1ps

package gcmp_pkg;

    localparam int MAX_CHANNELS_DEF = 512;

    localparam int COORD_W = 9;
    localparam int COUNT_W = 32;
    localparam int VALUE_W = 33;
    localparam int AXIS_W  = 10;
    localparam int REQ_W   = 2;

    localparam logic [AXIS_W-1:0] AXIS_LEN_RESET = 10'd512;

    localparam logic [REQ_W-1:0] REQ_SET_GATE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADD_VOXEL = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ_CELL = 2'd2;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_CLEAR,
        OP_GATE,
        OP_ADD,
        OP_READ
    } op_kind_t;

    // one memory operation issued by the sequencer
    typedef struct packed {
        op_kind_t             kind;
        logic                 ok;        // coords valid; for clear: gate entry in range
        logic                 dbl;       // diagonal read
        logic                 gate_bit;
        logic [COUNT_W-1:0]   count;
    } op_t;

    typedef struct packed {
        logic       s2_read;
        logic [1:0] occ;
    } rmw_stat_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD,
        ST_ONE
    } seq_state_t;

endpackage

// ===== sv/gated_cube_to_matrix_projection.sv =====
// top level: gated projection of a symmetric cube onto a folded count matrix
//
//   channel   direction   signals                                          handshake
//   s_        in          req_type, coord_x/y/z, voxel_count, gate_open    s_valid / s_ready
//   m_        out         cell_value                                       m_valid / m_ready
//   cfg_      in          axis_length                                      cfg_valid / cfg_ready
//
// add voxel issues one matrix read-modify-write per projected pair on a
// single ram port; set gate and read cell issue a single operation, unused codes none.
// a read result passes the request registers, the stage-2 register and the result queue.
// after reset a clearing sweep writes every matrix entry (and gate entry) once,
// with s_ready low meanwhile.
// s_ready drops when the two-slot result queue could overflow.
`timescale 1ns / 1ps

module gated_cube_to_matrix_projection #(
    parameter int MAX_CHANNELS = gcmp_pkg::MAX_CHANNELS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gcmp_pkg::AXIS_W-1:0]   cfg_axis_length,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [gcmp_pkg::REQ_W-1:0]    s_req_type,
    input  logic [gcmp_pkg::COORD_W-1:0]  s_coord_x,
    input  logic [gcmp_pkg::COORD_W-1:0]  s_coord_y,
    input  logic [gcmp_pkg::COORD_W-1:0]  s_coord_z,
    input  logic [gcmp_pkg::COUNT_W-1:0]  s_voxel_count,
    input  logic                          s_gate_open,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [gcmp_pkg::VALUE_W-1:0]  m_cell_value
);

    localparam int DEPTH  = MAX_CHANNELS * MAX_CHANNELS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int GATE_W = $clog2(MAX_CHANNELS);

    logic [gcmp_pkg::AXIS_W-1:0]  axis_length_reg;

    gcmp_pkg::op_t                op;
    gcmp_pkg::rmw_stat_t          stat;
    logic [ADDR_W-1:0]            cell_addr;
    logic [GATE_W-1:0]            gate_addr;
    logic [gcmp_pkg::COUNT_W-1:0] mx_rdata, mx_wdata;
    logic [ADDR_W-1:0]            mx_waddr;
    logic                         mx_we;
    logic [0:0]                   gt_rdata, gt_wdata;
    logic [GATE_W-1:0]            gt_waddr;
    logic                         gt_we;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_length_reg <= gcmp_pkg::AXIS_LEN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            axis_length_reg <= cfg_axis_length;
        end
    end

    gcmp_seq #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .axis_length   (axis_length_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_coord_x     (s_coord_x),
        .s_coord_y     (s_coord_y),
        .s_coord_z     (s_coord_z),
        .s_voxel_count (s_voxel_count),
        .s_gate_open   (s_gate_open),
        .stat          (stat),
        .op            (op),
        .cell_addr     (cell_addr),
        .gate_addr     (gate_addr)
    );

    gcmp_ram #(
        .WIDTH (gcmp_pkg::COUNT_W),
        .DEPTH (DEPTH)
    ) u_matrix_ram (
        .aclk  (aclk),
        .we    (mx_we),
        .waddr (mx_waddr),
        .wdata (mx_wdata),
        .raddr (cell_addr),
        .rdata (mx_rdata)
    );

    gcmp_ram #(
        .WIDTH (1),
        .DEPTH (MAX_CHANNELS)
    ) u_gate_ram (
        .aclk  (aclk),
        .we    (gt_we),
        .waddr (gt_waddr),
        .wdata (gt_wdata),
        .raddr (gate_addr),
        .rdata (gt_rdata)
    );

    gcmp_rmw #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_rmw (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .op           (op),
        .cell_addr    (cell_addr),
        .gate_addr    (gate_addr),
        .mx_rdata     (mx_rdata),
        .gt_rdata     (gt_rdata),
        .mx_we        (mx_we),
        .mx_waddr     (mx_waddr),
        .mx_wdata     (mx_wdata),
        .gt_we        (gt_we),
        .gt_waddr     (gt_waddr),
        .gt_wdata     (gt_wdata),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cell_value (m_cell_value),
        .stat         (stat)
    );

    // clearing sweep holds off items right after reset
    a_clear_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !s_ready)
        else $error("item accepted before clearing sweep");

    // result queue never holds more than two entries
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.occ != 2'd3)
        else $error("result queue overflow");

    // gate writes stay inside the table
    a_gate_write_range: assert property (@(posedge aclk) disable iff (!aresetn)
        gt_we |-> (int'(gt_waddr) < MAX_CHANNELS))
        else $error("gate write out of range");

endmodule

// ===== sv/gcmp_ram.sv =====
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module gcmp_ram #(
    parameter int WIDTH = gcmp_pkg::COUNT_W,
    parameter int DEPTH = gcmp_pkg::MAX_CHANNELS_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/gcmp_seq.sv =====
// item sequencer: clear sweep, request decode and per-update address issue
`timescale 1ns / 1ps

module gcmp_seq #(
    parameter int MAX_CHANNELS = gcmp_pkg::MAX_CHANNELS_DEF,
    localparam int DEPTH  = MAX_CHANNELS * MAX_CHANNELS,
    localparam int ADDR_W = $clog2(DEPTH),
    localparam int GATE_W = $clog2(MAX_CHANNELS)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [gcmp_pkg::AXIS_W-1:0]      axis_length,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [gcmp_pkg::REQ_W-1:0]       s_req_type,
    input  logic [gcmp_pkg::COORD_W-1:0]     s_coord_x,
    input  logic [gcmp_pkg::COORD_W-1:0]     s_coord_y,
    input  logic [gcmp_pkg::COORD_W-1:0]     s_coord_z,
    input  logic [gcmp_pkg::COUNT_W-1:0]     s_voxel_count,
    input  logic                             s_gate_open,
    input  gcmp_pkg::rmw_stat_t              stat,
    output gcmp_pkg::op_t                    op,
    output logic [ADDR_W-1:0]                cell_addr,
    output logic [GATE_W-1:0]                gate_addr
);

    gcmp_pkg::seq_state_t state_reg, state_next;
    logic [1:0]           step_reg, step_next;
    logic [ADDR_W-1:0]    clr_reg, clr_next;

    logic [gcmp_pkg::REQ_W-1:0]   req_reg;
    logic [gcmp_pkg::COORD_W-1:0] x_reg, y_reg, z_reg;
    logic [gcmp_pkg::COUNT_W-1:0] count_reg;
    logic                         gbit_reg;

    logic [gcmp_pkg::COORD_W-1:0] pa, pb, gch, hi, lo;
    logic                         use_pair;
    logic                         last;
    logic                         all_ok;
    logic                         accept;
    logic [2:0]                   pending;

    function automatic logic coord_ok(input logic [gcmp_pkg::COORD_W-1:0] c,
                                      input logic [gcmp_pkg::AXIS_W-1:0]  len);
        return ({1'b0, c} < len) && (int'(c) < MAX_CHANNELS);
    endfunction

    always_comb begin
        op         = '0;
        op.kind    = gcmp_pkg::OP_NOP;
        pa         = y_reg;
        pb         = x_reg;
        gch        = z_reg;
        use_pair   = 1'b0;
        last       = 1'b0;
        cell_addr  = '0;
        gate_addr  = '0;
        clr_next   = clr_reg;
        state_next = state_reg;
        step_next  = step_reg;
        all_ok     = coord_ok(x_reg, axis_length) && coord_ok(y_reg, axis_length)
                     && coord_ok(z_reg, axis_length);

        case (state_reg)
            gcmp_pkg::ST_CLEAR: begin
                op.kind     = gcmp_pkg::OP_CLEAR;
                op.ok       = (int'(clr_reg) < MAX_CHANNELS);
                op.gate_bit = 1'b1;
                cell_addr   = clr_reg;
                gate_addr   = GATE_W'(clr_reg);
                clr_next    = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = gcmp_pkg::ST_IDLE;
                end
            end
            gcmp_pkg::ST_ADD: begin
                // pair (y,x) gated by z, (z,x) by y, (z,y) by x
                case (step_reg)
                    2'd0: begin
                        pa = y_reg; pb = x_reg; gch = z_reg;
                    end
                    2'd1: begin
                        pa = z_reg; pb = x_reg; gch = y_reg;
                    end
                    default: begin
                        pa = z_reg; pb = y_reg; gch = x_reg;
                    end
                endcase
                op.kind   = all_ok ? gcmp_pkg::OP_ADD : gcmp_pkg::OP_NOP;
                op.ok     = all_ok;
                op.count  = count_reg;
                use_pair  = all_ok;
                gate_addr = all_ok ? GATE_W'(gch) : '0;
                last      = (step_reg == 2'd2);
                step_next = step_reg + 1'b1;
            end
            gcmp_pkg::ST_ONE: begin
                last = 1'b1;
                case (req_reg)
                    gcmp_pkg::REQ_READ_CELL: begin
                        op.kind  = gcmp_pkg::OP_READ;
                        op.ok    = coord_ok(x_reg, axis_length)
                                   && coord_ok(y_reg, axis_length);
                        op.dbl   = (x_reg == y_reg);
                        use_pair = op.ok;
                    end
                    gcmp_pkg::REQ_SET_GATE: begin
                        if (coord_ok(x_reg, axis_length)) begin
                            op.kind     = gcmp_pkg::OP_GATE;
                            op.ok       = 1'b1;
                            op.gate_bit = gbit_reg;
                            gate_addr   = GATE_W'(x_reg);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase

        hi = (pa > pb) ? pa : pb;
        lo = (pa > pb) ? pb : pa;
        if (use_pair) begin
            cell_addr = ADDR_W'(ADDR_W'(hi) * ADDR_W'(MAX_CHANNELS)) + ADDR_W'(lo);
        end

        // results that may still need a queue slot
        pending = 3'(stat.occ) + 3'(stat.s2_read) + 3'(op.kind == gcmp_pkg::OP_READ);
        s_ready = ((state_reg == gcmp_pkg::ST_IDLE) || last) && (pending <= 3'd1);
        accept  = s_valid && s_ready;

        if (last) begin
            state_next = gcmp_pkg::ST_IDLE;
            step_next  = 2'd0;
        end
        if (accept) begin
            state_next = (s_req_type == gcmp_pkg::REQ_ADD_VOXEL) ? gcmp_pkg::ST_ADD
                                                                 : gcmp_pkg::ST_ONE;
            step_next  = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gcmp_pkg::ST_CLEAR;
            step_reg  <= 2'd0;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg   <= s_req_type;
            x_reg     <= s_coord_x;
            y_reg     <= s_coord_y;
            z_reg     <= s_coord_z;
            count_reg <= s_voxel_count;
            gbit_reg  <= s_gate_open;
        end
    end

endmodule

// ===== sv/gcmp_rmw.sv =====
// read-modify-write stage with same-entry forwarding and result queue
`timescale 1ns / 1ps

module gcmp_rmw #(
    parameter int MAX_CHANNELS = gcmp_pkg::MAX_CHANNELS_DEF,
    localparam int DEPTH  = MAX_CHANNELS * MAX_CHANNELS,
    localparam int ADDR_W = $clog2(DEPTH),
    localparam int GATE_W = $clog2(MAX_CHANNELS)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gcmp_pkg::op_t                 op,
    input  logic [ADDR_W-1:0]             cell_addr,
    input  logic [GATE_W-1:0]             gate_addr,
    input  logic [gcmp_pkg::COUNT_W-1:0]  mx_rdata,
    input  logic [0:0]                    gt_rdata,
    output logic                          mx_we,
    output logic [ADDR_W-1:0]             mx_waddr,
    output logic [gcmp_pkg::COUNT_W-1:0]  mx_wdata,
    output logic                          gt_we,
    output logic [GATE_W-1:0]             gt_waddr,
    output logic [0:0]                    gt_wdata,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [gcmp_pkg::VALUE_W-1:0]  m_cell_value,
    output gcmp_pkg::rmw_stat_t           stat
);

    gcmp_pkg::op_t                s2_op_reg;
    logic [ADDR_W-1:0]            s2_cell_reg;
    logic [GATE_W-1:0]            s2_gate_reg;
    logic                         mx_fwd_hit_reg;
    logic [gcmp_pkg::COUNT_W-1:0] mx_fwd_data_reg;
    logic                         gt_fwd_hit_reg;
    logic [0:0]                   gt_fwd_data_reg;

    logic [1:0]                   q_cnt_reg, q_cnt_next;
    logic [gcmp_pkg::VALUE_W-1:0] q0_reg, q0_next, q1_reg, q1_next;

    logic [gcmp_pkg::COUNT_W-1:0] cur;
    logic [0:0]                   gate_now;
    logic [gcmp_pkg::COUNT_W:0]   sum;
    logic                         push;
    logic                         pop;
    logic [gcmp_pkg::VALUE_W-1:0] rd_value;

    always_comb begin
        // read data of the stage-2 op misses a write that landed on the same edge
        cur      = mx_fwd_hit_reg ? mx_fwd_data_reg : mx_rdata;
        gate_now = gt_fwd_hit_reg ? gt_fwd_data_reg : gt_rdata;
        sum      = {1'b0, cur} + {1'b0, s2_op_reg.count};

        mx_we    = 1'b0;
        mx_wdata = '0;
        gt_we    = 1'b0;
        gt_wdata = 1'b0;
        push     = 1'b0;
        rd_value = '0;

        case (s2_op_reg.kind)
            gcmp_pkg::OP_CLEAR: begin
                mx_we    = 1'b1;
                gt_we    = s2_op_reg.ok;
                gt_wdata = s2_op_reg.gate_bit;
            end
            gcmp_pkg::OP_ADD: begin
                mx_we    = gate_now[0];
                mx_wdata = sum[gcmp_pkg::COUNT_W] ? '1 : sum[gcmp_pkg::COUNT_W-1:0];
            end
            gcmp_pkg::OP_GATE: begin
                gt_we    = 1'b1;
                gt_wdata = s2_op_reg.gate_bit;
            end
            gcmp_pkg::OP_READ: begin
                push = 1'b1;
                if (s2_op_reg.ok) begin
                    rd_value = s2_op_reg.dbl ? {cur, 1'b0} : {1'b0, cur};
                end
            end
            default: begin
            end
        endcase

        mx_waddr = s2_cell_reg;
        gt_waddr = s2_gate_reg;
    end

    // two-entry result queue
    assign pop = m_valid && m_ready;

    always_comb begin
        q0_next    = q0_reg;
        q1_next    = q1_reg;
        q_cnt_next = q_cnt_reg;
        if (pop) begin
            q0_next    = q1_reg;
            q_cnt_next = q_cnt_reg - 1'b1;
        end
        if (push) begin
            if (q_cnt_next == 2'd0) begin
                q0_next = rd_value;
            end else begin
                q1_next = rd_value;
            end
            q_cnt_next = q_cnt_next + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_op_reg      <= '0;
            mx_fwd_hit_reg <= 1'b0;
            gt_fwd_hit_reg <= 1'b0;
            q_cnt_reg      <= 2'd0;
        end else begin
            s2_op_reg      <= op;
            mx_fwd_hit_reg <= mx_we && (mx_waddr == cell_addr);
            gt_fwd_hit_reg <= gt_we && (gt_waddr == gate_addr);
            q_cnt_reg      <= q_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        s2_cell_reg     <= cell_addr;
        s2_gate_reg     <= gate_addr;
        mx_fwd_data_reg <= mx_wdata;
        gt_fwd_data_reg <= gt_wdata;
        q0_reg          <= q0_next;
        q1_reg          <= q1_next;
    end

    assign m_valid      = (q_cnt_reg != 2'd0);
    assign m_cell_value = q0_reg;
    assign stat.s2_read = (s2_op_reg.kind == gcmp_pkg::OP_READ);
    assign stat.occ     = q_cnt_reg;

endmodule

// ===== tb/tb_gated_cube_to_matrix_projection.sv =====
// testbench for the gated cube to matrix projection block, self-checking
`timescale 1ns / 1ps

module tb_gated_cube_to_matrix_projection;
    import gcmp_pkg::*;

    localparam int                 MAX_CH          = MAX_CHANNELS_DEF;
    localparam logic [REQ_W-1:0]   REQ_UNUSED      = 2'd3;
    localparam int                 ITEMS_PER_PHASE = 232;
    localparam int                 SETTLE_CYCLES   = 8;
    localparam int                 TAIL_CYCLES     = 20;
    localparam int                 WATCHDOG_LIMIT  = 1000000;
    localparam int                 REPORT_LIMIT    = 10;

    // tracks gates and folded matrix, holds the cell values still to come back
    class cell_value_scoreboard;
        bit                 gate_passes [MAX_CH];
        bit [COUNT_W-1:0]   cell_count [int unsigned];
        bit [AXIS_W-1:0]    axis_len;
        bit [VALUE_W-1:0]   expected_cell_values [$];
        int unsigned        errors;

        function new();
            foreach (gate_passes[i]) gate_passes[i] = 1'b1;
            axis_len = AXIS_LEN_RESET;
            errors   = 0;
        endfunction

        function void set_axis_length(bit [AXIS_W-1:0] len);
            axis_len = len;
        endfunction

        function bit coord_valid(bit [COORD_W-1:0] c);
            return ({1'b0, c} < axis_len) && (int'(c) < MAX_CH);
        endfunction

        function int unsigned fold_index(bit [COORD_W-1:0] a, bit [COORD_W-1:0] b);
            int unsigned hi;
            int unsigned lo;
            hi = (a > b) ? 32'(a) : 32'(b);
            lo = (a > b) ? 32'(b) : 32'(a);
            return hi * MAX_CH + lo;
        endfunction

        function bit [COUNT_W-1:0] cell_at(int unsigned k);
            return cell_count.exists(k) ? cell_count[k] : '0;
        endfunction

        function void add_saturating(bit [COORD_W-1:0] a, bit [COORD_W-1:0] b,
                                     bit [COUNT_W-1:0] cnt);
            int unsigned        k;
            bit [COUNT_W:0]     sum;
            k   = fold_index(a, b);
            sum = {1'b0, cell_at(k)} + {1'b0, cnt};
            cell_count[k] = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
        endfunction

        function void note_request(bit [REQ_W-1:0] req, bit [COORD_W-1:0] x,
                                   bit [COORD_W-1:0] y, bit [COORD_W-1:0] z,
                                   bit [COUNT_W-1:0] cnt, bit g);
            bit [VALUE_W-1:0] v;
            case (req)
                REQ_SET_GATE: begin
                    if (coord_valid(x)) gate_passes[x] = g;
                end
                REQ_ADD_VOXEL: begin
                    if (coord_valid(x) && coord_valid(y) && coord_valid(z)) begin
                        // gates are all read before any of the three updates
                        if (gate_passes[z]) add_saturating(y, x, cnt);
                        if (gate_passes[y]) add_saturating(z, x, cnt);
                        if (gate_passes[x]) add_saturating(z, y, cnt);
                    end
                end
                REQ_READ_CELL: begin
                    v = '0;
                    if (coord_valid(x) && coord_valid(y)) begin
                        v = {1'b0, cell_at(fold_index(y, x))};
                        if (x == y) v = v << 1;
                    end
                    expected_cell_values.push_back(v);
                end
                default: ;
            endcase
        endfunction

        function void check_cell_value(bit [VALUE_W-1:0] got);
            bit [VALUE_W-1:0] want;
            if (expected_cell_values.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected result beat: cell_value %0h", got);
                return;
            end
            want = expected_cell_values.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("cell_value mismatch: expected %0h, got %0h", want, got);
            end
        endfunction

        function int unsigned pending();
            return expected_cell_values.size();
        endfunction

        function void report_leftover();
            if (expected_cell_values.size() != 0) begin
                errors++;
                $display("%0d read results never arrived", expected_cell_values.size());
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [AXIS_W-1:0]      cfg_axis_length;
    logic                   s_valid;
    logic                   s_ready;
    logic [REQ_W-1:0]       s_req_type;
    logic [COORD_W-1:0]     s_coord_x;
    logic [COORD_W-1:0]     s_coord_y;
    logic [COORD_W-1:0]     s_coord_z;
    logic [COUNT_W-1:0]     s_voxel_count;
    logic                   s_gate_open;
    logic                   m_valid;
    logic                   m_ready;
    logic [VALUE_W-1:0]     m_cell_value;

    cell_value_scoreboard   sb;
    int unsigned            tx_idle_pct;
    int unsigned            rx_idle_pct;
    int unsigned            stall_cycles;

    gated_cube_to_matrix_projection i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_axis_length (cfg_axis_length),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_coord_x       (s_coord_x),
        .s_coord_y       (s_coord_y),
        .s_coord_z       (s_coord_z),
        .s_voxel_count   (s_voxel_count),
        .s_gate_open     (s_gate_open),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cell_value    (m_cell_value)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // every beat is tracked here, so note and check keep a fixed order
    always @(posedge aclk) begin
        bit moved;
        if (aresetn) begin
            moved = 1'b0;
            if (cfg_valid && cfg_ready) begin
                sb.set_axis_length(cfg_axis_length);
                moved = 1'b1;
            end
            if (s_valid && s_ready) begin
                sb.note_request(s_req_type, s_coord_x, s_coord_y, s_coord_z,
                                s_voxel_count, s_gate_open);
                moved = 1'b1;
            end
            if (m_valid && m_ready) begin
                sb.check_cell_value(m_cell_value);
                moved = 1'b1;
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
        end else begin
            stall_cycles = 0;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_gated_cube_to_matrix_projection: FAIL");
            $finish;
        end
    end

    // all driving tasks start and end just after a falling edge
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [COORD_W-1:0] x,
                                input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
                                input logic [COUNT_W-1:0] cnt, input logic g);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_req_type    = req;
        s_coord_x     = x;
        s_coord_y     = y;
        s_coord_z     = z;
        s_voxel_count = cnt;
        s_gate_open   = g;
        s_valid       = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic write_axis_length(input logic [AXIS_W-1:0] len);
        s_valid         = 1'b0;
        cfg_axis_length = len;
        cfg_valid       = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // adds leave no result, so let the pipeline settle after the last read
    task automatic wait_drained();
        s_valid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [COORD_W-1:0] pick_coord(int unsigned len);
        int unsigned r;
        int unsigned lim;
        r   = $urandom_range(99);
        lim = (len > MAX_CH) ? MAX_CH : len;
        if (r < 10) return COORD_W'($urandom_range(MAX_CH - 1));
        // a narrow hot window keeps reads landing on accumulated cells
        if (r < 55) return COORD_W'($urandom_range(((lim < 8) ? lim : 8) - 1));
        return COORD_W'($urandom_range(lim - 1));
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 35) return $urandom_range(1000);
        if (r < 65) return $urandom_range(32'hFFFF_FFFF, 32'hF000_0000);
        return $urandom;
    endfunction

    task automatic send_random_request(input int unsigned len, output bit counted);
        int unsigned        pick;
        logic [REQ_W-1:0]   req;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        pick = $urandom_range(99);
        x    = pick_coord(len);
        y    = pick_coord(len);
        z    = pick_coord(len);
        if (pick < 45) begin
            req = REQ_ADD_VOXEL;
        end else if (pick < 75) begin
            req = REQ_READ_CELL;
        end else if (pick < 88) begin
            req = REQ_SET_GATE;
        end else if (pick < 92) begin
            req = REQ_UNUSED;
        end else begin
            req = REQ_W'($urandom_range(3));
            x   = COORD_W'($urandom_range(MAX_CH - 1));
            y   = COORD_W'($urandom_range(MAX_CH - 1));
            z   = COORD_W'($urandom_range(MAX_CH - 1));
        end
        send_request(req, x, y, z, pick_count(), $urandom_range(99) < 60);
        counted = (req != REQ_UNUSED);
    endtask

    task automatic run_directed();
        send_request(REQ_READ_CELL, 9'd0, 9'd0, 9'd511, 32'hFFFF_FFFF, 1'b1);
        // one voxel on the diagonal hits the same cell three times
        send_request(REQ_ADD_VOXEL, 9'd0, 9'd0, 9'd0, 32'hFFFF_FFFF, 1'b0);
        send_request(REQ_READ_CELL, 9'd0, 9'd0, 9'd0, 32'h0, 1'b0);
        send_request(REQ_ADD_VOXEL, 9'd511, 9'd0, 9'd5, 32'd7, 1'b0);
        send_request(REQ_READ_CELL, 9'd511, 9'd0, 9'd0, 32'h0, 1'b0);
        send_request(REQ_READ_CELL, 9'd0, 9'd511, 9'd0, 32'h0, 1'b0);
        send_request(REQ_READ_CELL, 9'd0, 9'd5, 9'd0, 32'h0, 1'b0);
        send_request(REQ_SET_GATE, 9'd5, 9'd0, 9'd0, 32'h0, 1'b0);
        send_request(REQ_ADD_VOXEL, 9'd1, 9'd2, 9'd5, 32'd100, 1'b1);
        send_request(REQ_READ_CELL, 9'd1, 9'd2, 9'd0, 32'h0, 1'b0);
        send_request(REQ_READ_CELL, 9'd5, 9'd1, 9'd0, 32'h0, 1'b0);
        send_request(REQ_SET_GATE, 9'd511, 9'd511, 9'd511, 32'hFFFF_FFFF, 1'b0);
        send_request(REQ_ADD_VOXEL, 9'd511, 9'd511, 9'd511, 32'd9, 1'b1);
        send_request(REQ_READ_CELL, 9'd511, 9'd511, 9'd0, 32'h0, 1'b0);
        send_request(REQ_SET_GATE, 9'd5, 9'd0, 9'd0, 32'h0, 1'b1);
        // off-diagonal saturation
        send_request(REQ_ADD_VOXEL, 9'd3, 9'd4, 9'd100, 32'hFFFF_FFF0, 1'b0);
        send_request(REQ_ADD_VOXEL, 9'd3, 9'd4, 9'd100, 32'hFFFF_FFF0, 1'b0);
        send_request(REQ_READ_CELL, 9'd3, 9'd4, 9'd0, 32'h0, 1'b0);
        send_request(REQ_ADD_VOXEL, 9'd2, 9'd2, 9'd2, 32'h0, 1'b0);
        send_request(REQ_UNUSED, 9'd511, 9'd511, 9'd511, 32'hFFFF_FFFF, 1'b1);
        send_request(REQ_READ_CELL, 9'd2, 9'd2, 9'd0, 32'h0, 1'b0);
        wait_drained();
        // shrink the axis so coordinates can fall out of range
        write_axis_length(10'd16);
        send_request(REQ_ADD_VOXEL, 9'd16, 9'd0, 9'd0, 32'd55, 1'b0);
        send_request(REQ_SET_GATE, 9'd300, 9'd0, 9'd0, 32'h0, 1'b0);
        send_request(REQ_READ_CELL, 9'd16, 9'd0, 9'd0, 32'h0, 1'b0);
        send_request(REQ_READ_CELL, 9'd3, 9'd4, 9'd0, 32'h0, 1'b0);
        send_request(REQ_READ_CELL, 9'd0, 9'd300, 9'd0, 32'h0, 1'b0);
    endtask

    initial begin
        int unsigned        axis_plan [8];
        int unsigned        done_items;
        int unsigned        phase_items;
        bit                 counted;
        axis_plan       = '{1, 512, 5, 511, 12, 3, 300, 512};
        sb              = new();
        tx_idle_pct     = 33;
        rx_idle_pct     = 54;
        stall_cycles    = 0;
        aresetn         = 1'b0;
        cfg_valid       = 1'b0;
        cfg_axis_length = AXIS_LEN_RESET;
        s_valid         = 1'b0;
        s_req_type      = REQ_SET_GATE;
        s_coord_x       = '0;
        s_coord_y       = '0;
        s_coord_z       = '0;
        s_voxel_count   = '0;
        s_gate_open     = 1'b0;
        m_ready         = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // cfg_ready is always high; the first request's handshake waits out the clearing sweep
        write_axis_length(10'd512);
        run_directed();

        done_items = 0;
        foreach (axis_plan[p]) begin
            wait_drained();
            write_axis_length(AXIS_W'(axis_plan[p]));
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                send_random_request(axis_plan[p], counted);
                if (counted) begin
                    phase_items++;
                    done_items++;
                end
                if (done_items >= 1240) begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end else if (done_items >= 620) begin
                    tx_idle_pct = 54;
                    rx_idle_pct = 33;
                end
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);
        sb.report_leftover();
        if (sb.errors == 0) begin
            $display("tb_gated_cube_to_matrix_projection: PASS");
        end else begin
            $display("tb_gated_cube_to_matrix_projection: FAIL");
        end
        $finish;
    end

endmodule
